>>> hw/rtl/clock_source_lock_quality_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Clock source lock quality tracker assertion macros
// Concurrent assertion shorthands used by the tracker core.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SOURCE_LOCK_QUALITY_TRACKER_TOP_MACROS_SVH
`define CLOCK_SOURCE_LOCK_QUALITY_TRACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CSLQT_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
// next-cycle implication
`define CSLQT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define CSLQT_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define CSLQT_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

>>> hw/rtl/cslqt_pkg.sv
// ----------------------------------------------------------------------------
// Clock source lock quality tracker package
// Widths, codes and shared types of the tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cslqt_pkg;

   localparam int TIME_BITS     = 32;
   localparam int REVISION_BITS = 16;
   localparam int COUNT_BITS    = 8;

   localparam int NOW_W       = 32;
   localparam int REVISION_W  = 16;
   localparam int THRESH_W    = 8;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CMP_W       = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

   localparam logic [THRESH_W-1:0]  LOCK_BEATS_RESET     = THRESH_W'(4);
   localparam logic [THRESH_W-1:0]  LOCK_PULSES_RESET    = THRESH_W'(2);
   localparam logic [TIMEOUT_W-1:0] FREEWHEEL_TIME_RESET = TIMEOUT_W'(2000);

   typedef enum logic [1:0] {
      GRADE_LOST      = 2'd0,
      GRADE_DEGRADED  = 2'd1,
      GRADE_FREEWHEEL = 2'd2,
      GRADE_LOCKED    = 2'd3
   } grade_type;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_BEAT    = 2'd1,
      MODE_PULSE   = 2'd2,
      MODE_REFRESH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SRC_INTERNAL = 2'd0,
      SRC_MIDI     = 2'd1,
      SRC_ANALOG   = 2'd2
   } source_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOCK_BEATS   = 2'd0,
      CSR_LOCK_PULSES  = 2'd1,
      CSR_FREEWHEEL_MS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0]  lock_beats;
      logic [THRESH_W-1:0]  analog_lock_pulses;
      logic [TIMEOUT_W-1:0] freewheel_timeout_ms;
   } cfg_type;

   typedef struct packed {
      mode_type       mode;
      logic [NOW_W-1:0] now_ms;
      logic [1:0]     clock_source;
      logic           midi_clock_active;
      logic           tempo_locked;
      logic           analog_clock_active;
      logic           transport_advancing;
      logic           transport_running;
      logic           tempo_nonzero;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            active_source;
      grade_type             internal_grade;
      grade_type             midi_grade;
      grade_type             analog_grade;
      logic [REVISION_W-1:0] revision;
      logic                  revised;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] source;
      grade_type  internal_grade;
      grade_type  midi_grade;
      grade_type  analog_grade;
   } grades_type;

   typedef struct packed {
      logic                  seen;
      logic [COUNT_BITS-1:0] count;
      logic [TIME_BITS-1:0]  last;
   } ext_track_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cslqt_ext_grade.sv
// ----------------------------------------------------------------------------
// External source grader
// Grades one external clock source and works out its tracking state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cslqt_ext_grade (
   input  wire logic                           selected,
   input  wire logic                           active,
   input  wire logic                           hint,
   input  wire logic                           advancing,
   input  wire logic [cslqt_pkg::TIME_BITS-1:0] now,
   input  wire logic [cslqt_pkg::THRESH_W-1:0]  threshold,
   input  wire logic [cslqt_pkg::TIMEOUT_W-1:0] timeout,
   input  wire cslqt_pkg::ext_track_type       track_pre,
   output cslqt_pkg::grade_type                grade,
   output cslqt_pkg::ext_track_type            track_post
);
   import cslqt_pkg::*;

   logic [TIME_BITS-1:0] elapsed;
   logic                 timed_out;
   logic                 count_met;

   assign elapsed   = now - track_pre.last;
   assign timed_out = (track_pre.last != '0) && (elapsed > TIME_BITS'(timeout));
   assign count_met = CMP_W'(track_pre.count) >= CMP_W'(threshold);

   always_comb begin
      track_post = track_pre;
      if (selected && active) begin
         track_post.seen = 1'b1;
         grade = (hint || count_met) ? GRADE_LOCKED : GRADE_DEGRADED;
      end else if (selected && track_pre.seen && advancing && !timed_out) begin
         grade = GRADE_FREEWHEEL;
      end else begin
         track_post.seen  = 1'b0;
         track_post.count = '0;
         grade = GRADE_LOST;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/cslqt_core.sv
// ----------------------------------------------------------------------------
// Tracker core
// Holds the tracking state and regrades all sources for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clock_source_lock_quality_tracker_top_macros.svh"

module cslqt_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire cslqt_pkg::req_item_type item,
   input  wire cslqt_pkg::cfg_type      cfg,
   output cslqt_pkg::rsp_item_type result
);
   import cslqt_pkg::*;

   ext_track_type             midi_ff, midi_in, midi_pre;
   ext_track_type             analog_ff, analog_in, analog_pre;
   grades_type                held_ff, held_in;
   logic [REVISION_BITS-1:0]  revision_ff, revision_in;
   logic [TIME_BITS-1:0]      now_t;
   grade_type                 midi_grade, analog_grade;
   logic                      bump;

   assign now_t = TIME_BITS'(item.now_ms);

   // apply beat or pulse to the tracking state before regrading
   always_comb begin
      midi_pre   = midi_ff;
      analog_pre = analog_ff;
      if (item.mode == MODE_BEAT && item.clock_source == SRC_MIDI &&
          item.midi_clock_active) begin
         midi_pre.count = sat_inc(midi_ff.count);
         midi_pre.last  = now_t;
      end
      if (item.mode == MODE_PULSE) begin
         analog_pre.last = now_t;
         if (item.analog_clock_active) begin
            analog_pre.count = sat_inc(analog_ff.count);
         end
      end
   end

   cslqt_ext_grade u_midi_grade (
      .selected  (item.clock_source == SRC_MIDI),
      .active    (item.midi_clock_active),
      .hint      (item.tempo_locked),
      .advancing (item.transport_advancing),
      .now       (now_t),
      .threshold (cfg.lock_beats),
      .timeout   (cfg.freewheel_timeout_ms),
      .track_pre (midi_pre),
      .grade     (midi_grade),
      .track_post(midi_in)
   );

   cslqt_ext_grade u_analog_grade (
      .selected  (item.clock_source == SRC_ANALOG),
      .active    (item.analog_clock_active),
      .hint      (1'b0),
      .advancing (item.transport_advancing),
      .now       (now_t),
      .threshold (cfg.analog_lock_pulses),
      .timeout   (cfg.freewheel_timeout_ms),
      .track_pre (analog_pre),
      .grade     (analog_grade),
      .track_post(analog_in)
   );

   always_comb begin
      held_in.source = (item.clock_source == SRC_MIDI || item.clock_source == SRC_ANALOG) ?
                       item.clock_source : SRC_INTERNAL;
      if (item.clock_source != SRC_INTERNAL) begin
         held_in.internal_grade = GRADE_LOST;
      end else if (item.transport_running) begin
         held_in.internal_grade = GRADE_LOCKED;
      end else if (item.tempo_nonzero) begin
         held_in.internal_grade = GRADE_DEGRADED;
      end else begin
         held_in.internal_grade = GRADE_LOST;
      end
      held_in.midi_grade   = midi_grade;
      held_in.analog_grade = analog_grade;
   end

   assign bump        = (item.mode != MODE_TICK) || (held_in != held_ff);
   assign revision_in = bump ? revision_ff + 1'b1 : revision_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         midi_ff     <= '0;
         analog_ff   <= '0;
         held_ff     <= '{source: SRC_INTERNAL, internal_grade: GRADE_LOST,
                          midi_grade: GRADE_LOST, analog_grade: GRADE_LOST};
         revision_ff <= '0;
      end else if (fire) begin
         midi_ff     <= midi_in;
         analog_ff   <= analog_in;
         held_ff     <= held_in;
         revision_ff <= revision_in;
      end
   end

   assign result.active_source  = held_in.source;
   assign result.internal_grade = held_in.internal_grade;
   assign result.midi_grade     = held_in.midi_grade;
   assign result.analog_grade   = held_in.analog_grade;
   assign result.revision       = REVISION_W'(revision_in);
   assign result.revised        = bump;

   `CSLQT_ASSERT_NEXT(a_rev_hold, clock, reset, !fire, $stable(revision_ff))
   `CSLQT_ASSERT_NEXT(a_rev_event, clock, reset, fire && item.mode != MODE_TICK,
                      revision_ff == REVISION_BITS'($past(revision_ff) + 1'b1))
   `CSLQT_ASSERT_IMPLY(a_midi_count_seen, clock, reset, midi_ff.count != '0, midi_ff.seen)
   `CSLQT_ASSERT_IMPLY(a_analog_count_seen, clock, reset, analog_ff.count != '0, analog_ff.seen)
   `CSLQT_ASSERT_IMPLY(a_freewheel_seen, clock, reset, held_ff.midi_grade == GRADE_FREEWHEEL, midi_ff.seen)

endmodule

`default_nettype wire

>>> hw/rtl/clock_source_lock_quality_tracker_top.sv
// ----------------------------------------------------------------------------
// Clock source lock quality tracker
// Grades internal, MIDI and analog clock sources from status events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event (monitor tick, beat, analog pulse or refresh)
//   with its timestamp and status flags; rsp_* returns one snapshot per event:
//   active source, three grades, the revision counter and a revised flag.
//   A transfer takes place on a clock edge with valid high and stall low.
//   Path: a request transfers into the input register; once the output is
//   free, the core result moves into the result register, rsp_valid rises
//   and the snapshot can transfer.
//   Throughput: one event per cycle while the output does not stall; the
//   regrade and counter update are combinational between the input and the result register.
//   Stall: while rsp_stall holds a result, the input register may still fill;
//   req_stall rises only when both registers are full and the output stalls.
//   Reset: synchronous; grades go to lost, source internal, counts, times and
//   revision clear, and the csr_* registers return to 4, 2 and 2000 ms.
//   Write csr_* only while no event is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_source_lock_quality_tracker_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_mode,
   input  wire logic [cslqt_pkg::NOW_W-1:0]      req_now_ms,
   input  wire logic [1:0]                       req_clock_source,
   input  wire logic                             req_midi_clock_active,
   input  wire logic                             req_tempo_locked,
   input  wire logic                             req_analog_clock_active,
   input  wire logic                             req_transport_advancing,
   input  wire logic                             req_transport_running,
   input  wire logic                             req_tempo_nonzero,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_active_source,
   output logic [1:0]                            rsp_internal_grade,
   output logic [1:0]                            rsp_midi_grade,
   output logic [1:0]                            rsp_analog_grade,
   output logic [cslqt_pkg::REVISION_W-1:0]      rsp_revision,
   output logic                                  rsp_revised,
   input  wire logic                             csr_write,
   input  wire logic [cslqt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cslqt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cslqt_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   cfg_type      cfg_ff, cfg_in;
   rsp_item_type core_result;
   logic         fire;

   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign fire      = s1_valid_ff && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_item_in  = '{mode:                mode_type'(req_mode),
                         now_ms:              req_now_ms,
                         clock_source:        req_clock_source,
                         midi_clock_active:   req_midi_clock_active,
                         tempo_locked:        req_tempo_locked,
                         analog_clock_active: req_analog_clock_active,
                         transport_advancing: req_transport_advancing,
                         transport_running:   req_transport_running,
                         tempo_nonzero:       req_tempo_nonzero};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LOCK_BEATS:   cfg_in.lock_beats           = THRESH_W'(csr_wdata);
            CSR_LOCK_PULSES:  cfg_in.analog_lock_pulses   = THRESH_W'(csr_wdata);
            CSR_FREEWHEEL_MS: cfg_in.freewheel_timeout_ms = TIMEOUT_W'(csr_wdata);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{lock_beats:           LOCK_BEATS_RESET,
                           analog_lock_pulses:   LOCK_PULSES_RESET,
                           freewheel_timeout_ms: FREEWHEEL_TIME_RESET};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   cslqt_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .result(core_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_active_source  = rsp_item_ff.active_source;
   assign rsp_internal_grade = rsp_item_ff.internal_grade;
   assign rsp_midi_grade     = rsp_item_ff.midi_grade;
   assign rsp_analog_grade   = rsp_item_ff.analog_grade;
   assign rsp_revision       = rsp_item_ff.revision;
   assign rsp_revised        = rsp_item_ff.revised;

endmodule

`default_nettype wire
